// File: rtl/cbpe_pkg.sv
// Shared constants for the cubic Bezier point evaluator: register map of the configuration port.
package cbpe_pkg;

    localparam int CFG_IDX_BITS = 4;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_P0_X = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_P0_Y = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_P1_X = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_P1_Y = cfg_idx_t'(3);
    localparam cfg_idx_t CFG_P2_X = cfg_idx_t'(4);
    localparam cfg_idx_t CFG_P2_Y = cfg_idx_t'(5);
    localparam cfg_idx_t CFG_P3_X = cfg_idx_t'(6);
    localparam cfg_idx_t CFG_P3_Y = cfg_idx_t'(7);

endpackage

// File: rtl/cubic_bezier_point_eval_unit.sv
// Cubic Bezier point evaluator: eight-stage pipeline that maps t to one 2-D curve point.
//
// Usage:
//   Write the four control points P0..P3 (x and y, signed COORD_BITS) through the cfg_* port,
//   index 0..7 in the order p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y. Writes to higher
//   indexes are dropped. cfg_ready is always high. Write only while no item is in flight.
//   Then stream t values (unsigned, T_FRAC_BITS fraction bits, 2^T_FRAC_BITS = 1.0) on the
//   s_axis side; values above 1.0 are clamped to 1.0. Each item yields one point on the
//   m_axis side, x in the low half of m_tdata and y above it, rounded to nearest (ties up)
//   and saturated to the signed COORD_BITS range.
// Throughput and stages:
//   One item per clock, sustained while the receiver takes every result. A result passes
//   through the input register, three multiply stages, three round-and-add stages and
//   the saturating output register before it shows on m_tvalid. The polynomial
//   coefficients are refreshed from the point registers in the cycle after each write.
// Reset and stall:
//   aresetn (synchronous, active low) empties the pipeline and clears the control points.
//   When the receiver stalls, the output register holds its item and each stage holds only
//   if the stage after it is full, so bubbles close up and s_tready falls only once every
//   stage is occupied. Nothing is dropped or repeated.
module cubic_bezier_point_eval_unit #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  cbpe_pkg::cfg_idx_t                     cfg_index,
    input  logic [COORD_BITS-1:0]                  cfg_data,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((T_FRAC_BITS+8)/8)*8-1:0]       s_tdata,   // [T_FRAC_BITS:0] param_t
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata    // point_x, then point_y
);

    // Fraction bits kept during the Horner steps.
    localparam int KEEP_A    = T_FRAC_BITS;
    localparam int KEEP_B    = 58 - COORD_BITS - T_FRAC_BITS;
    localparam int KB        = (KEEP_A < KEEP_B) ? KEEP_A : KEEP_B;
    localparam int TW        = T_FRAC_BITS + 1;              // clamped t width
    localparam int CFW       = COORD_BITS + 4;               // coefficient width
    localparam int VW        = COORD_BITS + KB + 6;          // Horner accumulator width
    localparam int PW        = VW + T_FRAC_BITS + 2;         // product width
    localparam int MW        = ((2*COORD_BITS+7)/8)*8;
    localparam int STAGES    = 7;                            // stages ahead of the output reg

    localparam logic [TW-1:0]        T_ONE  = TW'(1) << T_FRAC_BITS;
    localparam logic signed [PW:0]   HALF_T = (PW+1)'(1) << (T_FRAC_BITS-1);
    localparam logic signed [VW:0]   HALF_K = (VW+1)'(1) << (KB-1);
    localparam logic signed [VW:0]   SAT_HI = {{(VW-COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [VW:0]   SAT_LO = {{(VW-COORD_BITS+2){1'b1}}, {(COORD_BITS-1){1'b0}}};

    // ---------------------------------------------------------------- configuration
    // Index 0 is x, 1 is y for every per-axis array below.
    logic signed [COORD_BITS-1:0] p0_reg [2];
    logic signed [COORD_BITS-1:0] p1_reg [2];
    logic signed [COORD_BITS-1:0] p2_reg [2];
    logic signed [COORD_BITS-1:0] p3_reg [2];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < 2; l++) begin
                p0_reg[l] <= '0;
                p1_reg[l] <= '0;
                p2_reg[l] <= '0;
                p3_reg[l] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cbpe_pkg::CFG_P0_X: p0_reg[0] <= cfg_data;
                cbpe_pkg::CFG_P0_Y: p0_reg[1] <= cfg_data;
                cbpe_pkg::CFG_P1_X: p1_reg[0] <= cfg_data;
                cbpe_pkg::CFG_P1_Y: p1_reg[1] <= cfg_data;
                cbpe_pkg::CFG_P2_X: p2_reg[0] <= cfg_data;
                cbpe_pkg::CFG_P2_Y: p2_reg[1] <= cfg_data;
                cbpe_pkg::CFG_P3_X: p3_reg[0] <= cfg_data;
                cbpe_pkg::CFG_P3_Y: p3_reg[1] <= cfg_data;
                default: ;  // drop writes beyond the register map
            endcase
        end
    end

    // Polynomial coefficients, refreshed every cycle from the point registers.
    logic signed [CFW-1:0] coef_a_reg [2];
    logic signed [CFW-1:0] coef_b_reg [2];
    logic signed [CFW-1:0] coef_c_reg [2];
    logic signed [CFW-1:0] coef_a_next [2];
    logic signed [CFW-1:0] coef_b_next [2];
    logic signed [CFW-1:0] coef_c_next [2];

    always_comb begin
        logic signed [CFW-1:0] d10, d21;
        d10 = '0;
        d21 = '0;
        for (int l = 0; l < 2; l++) begin
            d10 = CFW'(p1_reg[l]) - CFW'(p0_reg[l]);
            d21 = CFW'(p2_reg[l]) - CFW'(p1_reg[l]);
            coef_c_next[l] = (d10 <<< 1) + d10;
            coef_b_next[l] = (d21 <<< 1) + d21 - coef_c_next[l];
            coef_a_next[l] = CFW'(p3_reg[l]) - CFW'(p0_reg[l]) - coef_c_next[l]
                             - coef_b_next[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < 2; l++) begin
                coef_a_reg[l] <= '0;
                coef_b_reg[l] <= '0;
                coef_c_reg[l] <= '0;
            end
        end else begin
            coef_a_reg <= coef_a_next;
            coef_b_reg <= coef_b_next;
            coef_c_reg <= coef_c_next;
        end
    end

    // ---------------------------------------------------------------- flow control
    // Stage i loads when it is empty or the stage after it moves on this cycle.
    logic [STAGES-1:0] vld_reg;
    logic              m_valid_reg;
    logic [STAGES:0]   adv;

    always_comb begin
        adv[STAGES] = !m_valid_reg || m_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (adv[STAGES]) begin
                m_valid_reg <= vld_reg[STAGES-1];
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    // t travels with the item up to the last multiply stage.
    logic [TW-1:0] t_reg [5];
    logic [TW-1:0] t_next;

    always_comb begin
        t_next = s_tdata[TW-1:0];
        if (t_next > T_ONE) begin
            t_next = T_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            t_reg[0] <= t_next;
        end
        for (int i = 1; i < 5; i++) begin
            if (adv[i]) begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    logic signed [PW-1:0] prod1_reg [2];
    logic signed [VW-1:0] v1_reg    [2];
    logic signed [PW-1:0] prod2_reg [2];
    logic signed [VW-1:0] v2_reg    [2];
    logic signed [PW-1:0] prod3_reg [2];
    logic signed [VW-1:0] v3_reg    [2];
    logic [COORD_BITS-1:0] point_reg [2];

    logic signed [PW-1:0] prod1_next [2];
    logic signed [VW-1:0] v1_next    [2];
    logic signed [PW-1:0] prod2_next [2];
    logic signed [VW-1:0] v2_next    [2];
    logic signed [PW-1:0] prod3_next [2];
    logic signed [VW-1:0] v3_next    [2];
    logic [COORD_BITS-1:0] point_next [2];

    always_comb begin
        logic signed [TW:0]   t0_s, t2_s, t4_s;
        logic signed [VW-1:0] a_k;
        logic signed [PW:0]   rnd1, rnd2, rnd3;
        logic signed [VW:0]   fin;
        t0_s = signed'({1'b0, t_reg[0]});
        t2_s = signed'({1'b0, t_reg[2]});
        t4_s = signed'({1'b0, t_reg[4]});
        a_k  = '0;
        rnd1 = '0;
        rnd2 = '0;
        rnd3 = '0;
        fin  = '0;
        for (int l = 0; l < 2; l++) begin
            // stage 1: a * 2^K * t
            a_k           = VW'(coef_a_reg[l]) <<< KB;
            prod1_next[l] = a_k * t0_s;
            // stage 2: round and add b
            rnd1          = (PW+1)'(prod1_reg[l]) + HALF_T;
            v1_next[l]    = VW'(rnd1 >>> T_FRAC_BITS) + (VW'(coef_b_reg[l]) <<< KB);
            // stage 3
            prod2_next[l] = v1_reg[l] * t2_s;
            // stage 4: round and add c
            rnd2          = (PW+1)'(prod2_reg[l]) + HALF_T;
            v2_next[l]    = VW'(rnd2 >>> T_FRAC_BITS) + (VW'(coef_c_reg[l]) <<< KB);
            // stage 5
            prod3_next[l] = v2_reg[l] * t4_s;
            // stage 6: round and add p0
            rnd3          = (PW+1)'(prod3_reg[l]) + HALF_T;
            v3_next[l]    = VW'(rnd3 >>> T_FRAC_BITS) + (VW'(p0_reg[l]) <<< KB);
            // output: drop the kept fraction, then clamp to the coordinate range
            fin = ((VW+1)'(v3_reg[l]) + HALF_K) >>> KB;
            priority if (fin > SAT_HI) begin
                point_next[l] = SAT_HI[COORD_BITS-1:0];
            end else if (fin < SAT_LO) begin
                point_next[l] = SAT_LO[COORD_BITS-1:0];
            end else begin
                point_next[l] = fin[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) prod1_reg <= prod1_next;
        if (adv[2]) v1_reg    <= v1_next;
        if (adv[3]) prod2_reg <= prod2_next;
        if (adv[4]) v2_reg    <= v2_next;
        if (adv[5]) prod3_reg <= prod3_next;
        if (adv[6]) v3_reg    <= v3_next;
        if (adv[STAGES]) point_reg <= point_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MW'({point_reg[1], point_reg[0]});

endmodule

// File: tb/tb_cubic_bezier_point_eval_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cubic Bezier point evaluator: corners, then random t streams.
module tb_cubic_bezier_point_eval_unit;

    localparam int COORD_BITS   = 16;
    localparam int T_FRAC_BITS  = 16;
    localparam int S_BITS       = ((T_FRAC_BITS + 8) / 8) * 8;
    localparam int M_BITS       = ((2 * COORD_BITS + 7) / 8) * 8;
    // fraction bits carried through the Horner steps
    localparam int KEEP_BITS    = (T_FRAC_BITS < 58 - COORD_BITS - T_FRAC_BITS) ?
                                  T_FRAC_BITS : 58 - COORD_BITS - T_FRAC_BITS;
    localparam int PIPE_DEPTH   = 7;
    localparam int T_ONE        = 1 << T_FRAC_BITS;
    localparam int T_MAX        = (1 << (T_FRAC_BITS + 1)) - 1;
    localparam int REG_COUNT    = 8;
    localparam int SECTIONS     = 6;
    localparam int SECTION_LEN  = 125;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // x sits in the low half of the result word, y above it
    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    localparam coord_t COORD_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
    localparam coord_t COORD_MIN = coord_t'(-(1 << (COORD_BITS - 1)));

    // Holds a copy of the control points and the curve points still owed by the block.
    class curve_point_tracker;
        coord_t ctrl[REG_COUNT];
        point_t due_points[$];
        int     mismatches;

        function new();
            foreach (ctrl[i]) ctrl[i] = '0;
            mismatches = 0;
        endfunction

        // drop writes above the register map, as the block does
        function void write_reg(cbpe_pkg::cfg_idx_t idx, coord_t value);
            if (idx <= cbpe_pkg::CFG_P3_Y) begin
                ctrl[idx] = value;
            end
        endfunction

        // floor((x + half) / 2^s); arithmetic shift of a signed longint is a floor
        function longint round_q(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function coord_t axis_at(coord_t q0, coord_t q1, coord_t q2, coord_t q3, longint t);
            longint one_k, c, b, a, v, r, hi, lo;
            one_k = longint'(1) << KEEP_BITS;
            c = 3 * (longint'(q1) - longint'(q0));
            b = 3 * (longint'(q2) - longint'(q1)) - c;
            a = longint'(q3) - longint'(q0) - c - b;
            // Horner form: ((a*t + b)*t + c)*t + p0, KEEP_BITS of fraction between steps
            v = a * one_k;
            v = b * one_k + round_q(v * t, T_FRAC_BITS);
            v = c * one_k + round_q(v * t, T_FRAC_BITS);
            v = longint'(q0) * one_k + round_q(v * t, T_FRAC_BITS);
            r = round_q(v, KEEP_BITS);
            hi = (longint'(1) << (COORD_BITS - 1)) - 1;
            lo = -hi - 1;
            if (r > hi) begin
                r = hi;
            end
            if (r < lo) begin
                r = lo;
            end
            return coord_t'(r);
        endfunction

        // note an accepted t and queue the point it must produce
        function void note_param(logic [T_FRAC_BITS:0] raw);
            longint t;
            point_t p;
            // clamp anything above one to exactly one
            t = (raw > T_ONE) ? longint'(T_ONE) : longint'(raw);
            p.x = axis_at(ctrl[cbpe_pkg::CFG_P0_X], ctrl[cbpe_pkg::CFG_P1_X],
                          ctrl[cbpe_pkg::CFG_P2_X], ctrl[cbpe_pkg::CFG_P3_X], t);
            p.y = axis_at(ctrl[cbpe_pkg::CFG_P0_Y], ctrl[cbpe_pkg::CFG_P1_Y],
                          ctrl[cbpe_pkg::CFG_P2_Y], ctrl[cbpe_pkg::CFG_P3_Y], t);
            due_points.insert(due_points.size(), p);
        endfunction

        // compare one accepted result with the oldest owed point
        function void check_point(point_t got);
            point_t want;
            if (due_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: point x=%0d y=%0d with none outstanding", got.x, got.y);
                end
                return;
            end
            want = due_points.pop_front();
            if (got.x !== want.x) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: point_x expected %0d, got %0d", want.x, got.x);
                end
            end
            if (got.y !== want.y) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: point_y expected %0d, got %0d", want.y, got.y);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cbpe_pkg::cfg_idx_t    cfg_index;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_BITS-1:0]     s_tdata;   // [T_FRAC_BITS:0] param_t, zeros above
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_BITS-1:0]     m_tdata;   // point_x, then point_y

    // percent of cycles in which the sender idles / the receiver stalls
    int                    send_idle_pct;
    int                    recv_stall_pct;
    curve_point_tracker    tracker;

    cubic_bezier_point_eval_unit #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: check every accepted result, then pick next cycle's ready at random.
    // Values read here are the ones from just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_point(point_t'(m_tdata[2*COORD_BITS-1:0]));
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one t, idling first at the current rate, and hold it until accepted.
    // valid is lowered only inside the idle loop, so it never drops and rises in one step.
    task automatic send_param(int t);
        logic [T_FRAC_BITS:0] raw;
        raw = (T_FRAC_BITS + 1)'(t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= S_BITS'(raw);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_param(raw);
    endtask

    // Write all eight control-point registers, then one stray index above the map.
    task automatic load_curve(input coord_t pts[REG_COUNT]);
        cbpe_pkg::cfg_idx_t stray_idx;
        coord_t             stray_val;
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cbpe_pkg::cfg_idx_t'(cbpe_pkg::CFG_P0_X + i);
            cfg_data  <= pts[i];
            do @(posedge aclk); while (!cfg_ready);
            tracker.write_reg(cbpe_pkg::cfg_idx_t'(cbpe_pkg::CFG_P0_X + i), pts[i]);
        end
        // the block must drop this one; a sloppy decode would clobber a point
        stray_idx = cbpe_pkg::cfg_idx_t'(cbpe_pkg::CFG_P3_Y + 1 + $urandom_range(7));
        stray_val = coord_t'($urandom);
        cfg_index <= stray_idx;
        cfg_data  <= stray_val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(stray_idx, stray_val);
        cfg_valid <= 1'b0;
    endtask

    // Advance until every owed point has come back; every t yields a point,
    // so an empty queue means an empty pipeline.
    task automatic wait_drained();
        while (tracker.due_points.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        coord_t pts[REG_COUNT];
        tracker        = new();
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = cbpe_pkg::CFG_P0_X;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Points at reset are all zero: the curve is flat at the origin.
        send_param(0);
        send_param(T_ONE);
        send_param(T_MAX);
        s_tvalid <= 1'b0;
        wait_drained();

        // Zig-zag between the extremes of the coordinate range in x and in y.
        pts = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
        load_curve(pts);
        send_param(0);
        send_param(1);
        send_param(T_ONE / 4);
        send_param(T_ONE / 2);
        send_param(T_ONE - 1);
        send_param(T_ONE);
        send_param(T_ONE + 1);               // above one: clamps to one
        send_param(T_MAX);
        send_param(T_ONE | (T_ONE / 3));      // top bit set with mixed low bits
        s_tvalid <= 1'b0;
        wait_drained();

        // At t = 1/2 this curve lands on +0.5 in x and -0.5 in y: both round up.
        pts = '{coord_t'(1), coord_t'(-1), coord_t'(1), coord_t'(-1),
                coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0)};
        load_curve(pts);
        send_param(T_ONE / 2);
        send_param(T_ONE / 4);
        send_param(3 * T_ONE / 4);
        send_param(T_ONE / 2 + 1);
        send_param(T_ONE / 2 - 1);
        s_tvalid <= 1'b0;

        // Random sections: new control points and a new idle pattern each time.
        for (int sec = 0; sec < SECTIONS; sec++) begin
            wait_drained();
            for (int i = 0; i < REG_COUNT; i++) begin
                unique case (sec)
                    1: pts[i] = COORD_MAX;
                    2: pts[i] = COORD_MIN;
                    3: pts[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    4: pts[i] = coord_t'($signed($urandom_range(128)) - 64);
                    default: pts[i] = coord_t'($urandom);
                endcase
            end
            load_curve(pts);
            unique case (sec % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            for (int n = 0; n < SECTION_LEN; n++) begin
                // mostly the legal range, now and then anything the field holds
                if ($urandom_range(7) == 0) begin
                    send_param(int'($urandom_range(T_MAX)));
                end else begin
                    send_param(int'($urandom_range(T_ONE)));
                end
            end
            s_tvalid <= 1'b0;
        end

        // Drain, then linger a little to catch any stray extra result.
        wait_drained();
        repeat (PIPE_DEPTH + 3) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.due_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
